// ===== src/lpfd_pkg.sv =====
// Package with the shared types and constants of the length-prefixed frame decoder.
package lpfd_pkg;

  localparam int unsigned HDR_BYTES = 16;
  localparam int unsigned LEN_END = 4;
  localparam int unsigned TYPE_END = 8;
  localparam int unsigned IDX_W = $clog2(HDR_BYTES);

  localparam logic [31:0] MAX_BODY_RESET = 32'd65536;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] msg_type;
    logic [63:0] msg_id;
    logic [31:0] body_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

// ===== src/length_prefixed_frame_decoder.sv =====
// Top level of the length-prefixed frame decoder: header parser and payload counter.
//
// The block takes a byte stream on data_byte, one byte per item, accepted at a
// clock edge with data_valid high and data_stall low. Each message starts with
// a 16-byte big-endian header: body length, message type and message id.
// After the last header byte one result item comes out: a header result, or a
// length error when the body length exceeds max_body_length. Each payload byte
// then gives one payload result; last marks the final item of a message.
// After a length error every byte is consumed without a result until reset.
// A result appears on the output channel in the cycle after the byte that causes
// it is accepted, and one byte is accepted in every cycle with data_valid high and data_stall low.
// The output register holds a result while result_stall is high; data_stall is
// raised only while that register is full and the receiver stalls.
// Reset sets max_body_length to 65536 and returns to the header phase.
// cfg_we writes cfg_data into max_body_length; it is used at the next header.
module length_prefixed_frame_decoder
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [31:0] msg_type,
  output logic [63:0] msg_id,
  output logic [31:0] body_length,
  output logic [7:0]  payload_byte,
  output logic        last
);

  logic [31:0]      max_body_length;
  phase_t           phase, phase_next;
  logic [IDX_W-1:0] header_index, header_index_next;
  logic [31:0]      length_shift, length_shift_next;
  logic [31:0]      type_shift, type_shift_next;
  logic [63:0]      id_shift, id_shift_next;
  logic [31:0]      bytes_remaining, bytes_remaining_next;
  logic             accept;
  logic             emit;
  result_t          res;
  result_t          held;

  assign data_stall = result_valid & result_stall;
  assign accept = data_valid & ~data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_length <= MAX_BODY_RESET;
    end else if (cfg_we) begin
      max_body_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_index    <= '0;
      length_shift    <= '0;
      type_shift      <= '0;
      id_shift        <= '0;
      bytes_remaining <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      length_shift    <= length_shift_next;
      type_shift      <= type_shift_next;
      id_shift        <= id_shift_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    length_shift_next    = length_shift;
    type_shift_next      = type_shift;
    id_shift_next        = id_shift;
    bytes_remaining_next = bytes_remaining;
    emit                 = 1'b0;
    res                  = '0;
    case (phase)
      PH_PAYLOAD: begin
        bytes_remaining_next = bytes_remaining - 32'd1;
        emit                 = 1'b1;
        res.kind             = KIND_PAYLOAD;
        res.payload_byte     = data_byte;
        res.last             = (bytes_remaining_next == '0);
        if (bytes_remaining_next == '0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_HEADER: begin
        header_index_next = header_index + 1'b1;
        if (header_index < IDX_W'(LEN_END)) begin
          length_shift_next = {length_shift[23:0], data_byte};
        end else if (header_index < IDX_W'(TYPE_END)) begin
          type_shift_next = {type_shift[23:0], data_byte};
        end else begin
          id_shift_next = {id_shift[55:0], data_byte};
        end
        if (header_index == IDX_W'(HDR_BYTES - 1)) begin
          emit = 1'b1;
          if (length_shift > max_body_length) begin
            phase_next      = PH_DROP;
            res.kind        = KIND_ERROR;
            res.body_length = length_shift;
            res.last        = 1'b1;
          end else begin
            res.kind        = KIND_HEADER;
            res.msg_type    = type_shift;
            res.msg_id      = id_shift_next;
            res.body_length = length_shift;
            res.last        = (length_shift == '0);
            if (length_shift != '0) begin
              phase_next           = PH_PAYLOAD;
              bytes_remaining_next = length_shift;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  lpfd_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load         (accept & emit),
    .res          (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .held         (held)
  );

  assign kind         = held.kind;
  assign msg_type     = held.msg_type;
  assign msg_id       = held.msg_id;
  assign body_length  = held.body_length;
  assign payload_byte = held.payload_byte;
  assign last         = held.last;

endmodule

// ===== src/lpfd_out_stage.sv =====
// Output register that holds one result item until the receiver takes it.
module lpfd_out_stage
  import lpfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    result_stall,
  output logic    result_valid,
  output result_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule
